// File: src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants
// Configuration layout, register indexes and the result record of the
// printable string extractor.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int OUT_W = 28;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [OUT_W-1:0] OUT_LIMIT = '1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DETECT_WIDE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRINTABLE_LOW     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRINTABLE_HIGH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_PRINTABLE = 3'd4;

    // control characters classed printable by the control flag
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    typedef struct packed {
        logic [15:0] min_length;
        logic        detect_wide;
        logic [7:0]  printable_low;
        logic [7:0]  printable_high;
        logic        control_printable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        min_length:        16'd4,
        detect_wide:       1'b1,
        printable_low:     8'd32,
        printable_high:    8'd126,
        control_printable: 1'b1
    };

    typedef struct packed {
        logic [OUT_W-1:0] start_offset;
        logic [OUT_W-1:0] length_bytes;
        logic             is_wide;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// File: src/printable_string_extractor_core.sv
// ----------------------------------------------------------------------------
// printable_string_extractor_core: narrow and wide string finder
// Scans a byte stream and reports runs of printable characters.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter through push/full, one per cycle while full is low; set
//   chunk_start with the first byte of each chunk to restart offsets and
//   drop any open run. A result (start_offset, length_bytes, is_wide) is
//   presented while empty is low and taken with pop.
//   Configuration goes through cfg_valid/cfg_ready (always ready) with
//   cfg_index selecting the register; write only while the block is idle.
//   Throughput is one byte per cycle while full is low; the run tracker
//   updates its state once per byte taken. A result is registered in the
//   record queue, then in the result queue, before it shows on the output.
//   A four-entry record queue sits between the tracker and the result
//   builder, and a two-entry result queue drives the outputs. When the
//   receiver stops popping, the queues fill and full rises; bytes keep
//   flowing until then.
//   Reset empties both queues, clears run state and offset and loads the
//   default configuration.
// ----------------------------------------------------------------------------
module printable_string_extractor_core #(
    parameter int OFFSET_BITS = 28
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      data_byte,
    input  logic                            chunk_start,
    output logic                            empty,
    input  logic                            pop,
    output logic [pse_pkg::OUT_W-1:0]       start_offset,
    output logic [pse_pkg::OUT_W-1:0]       length_bytes,
    output logic                            is_wide,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int REC_W = 2 * OFFSET_BITS + 2;
    localparam int REC_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    pse_pkg::cfg_t cfg_reg, cfg_next;

    logic                   in_valid;
    logic                   rec_valid, rec_bias, rec_wide;
    logic [OFFSET_BITS-1:0] rec_run, rec_pos;
    logic [REC_W-1:0]       rec_wdata, rec_rdata;
    logic                   rec_full, rec_empty, rec_pop;
    logic                   res_full, res_push;
    pse_pkg::result_t       res_w, res_r;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pse_pkg::REG_MIN_LENGTH:        cfg_next.min_length = cfg_data;
                pse_pkg::REG_DETECT_WIDE:       cfg_next.detect_wide = cfg_data[0];
                pse_pkg::REG_PRINTABLE_LOW:     cfg_next.printable_low = cfg_data[7:0];
                pse_pkg::REG_PRINTABLE_HIGH:    cfg_next.printable_high = cfg_data[7:0];
                pse_pkg::REG_CONTROL_PRINTABLE: cfg_next.control_printable = cfg_data[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= pse_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign full     = rec_full;
    assign in_valid = push && !rec_full;

    pse_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .data_byte   (data_byte),
        .chunk_start (chunk_start),
        .rec_valid   (rec_valid),
        .rec_run     (rec_run),
        .rec_pos     (rec_pos),
        .rec_bias    (rec_bias),
        .rec_wide    (rec_wide)
    );

    assign rec_wdata = {rec_run, rec_pos, rec_bias, rec_wide};

    pse_fifo #(
        .WIDTH (REC_W),
        .DEPTH (REC_DEPTH)
    ) u_rec_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec_wdata),
        .rd_en   (rec_pop),
        .rd_data (rec_rdata),
        .full    (rec_full),
        .empty   (rec_empty)
    );

    pse_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .rec_empty (rec_empty),
        .rec_run   (rec_rdata[REC_W-1 -: OFFSET_BITS]),
        .rec_pos   (rec_rdata[OFFSET_BITS+1 -: OFFSET_BITS]),
        .rec_bias  (rec_rdata[1]),
        .rec_wide  (rec_rdata[0]),
        .rec_pop   (rec_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_w)
    );

    pse_fifo #(
        .WIDTH (pse_pkg::RESULT_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_w),
        .rd_en   (pop),
        .rd_data (res_r),
        .full    (res_full),
        .empty   (empty)
    );

    assign start_offset = res_r.start_offset;
    assign length_bytes = res_r.length_bytes;
    assign is_wide      = res_r.is_wide;

endmodule

// File: src/pse_fifo.sv
// ----------------------------------------------------------------------------
// pse_fifo: small register queue
// First-word-fall-through queue built from flops; head is on rd_data while
// empty is low.
// ----------------------------------------------------------------------------
module pse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front: byte classifier and run tracker
// Classes each byte, walks the three-byte printability table and raises a
// close record when a reportable run ends.
// ----------------------------------------------------------------------------
module pse_front #(
    parameter int OFFSET_BITS = 28
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pse_pkg::cfg_t          cfg,
    input  logic                   in_valid,
    input  logic [7:0]             data_byte,
    input  logic                   chunk_start,
    output logic                   rec_valid,
    output logic [OFFSET_BITS-1:0] rec_run,
    output logic [OFFSET_BITS-1:0] rec_pos,
    output logic                   rec_bias,
    output logic                   rec_wide
);

    // compare width holds min_length + 1 and any run length
    localparam int CW = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;

    logic [7:0]             prev_byte_reg, prev_byte_next;
    logic                   p1_reg, p1_next;
    logic                   p2_reg, p2_next;
    logic [OFFSET_BITS-1:0] run_reg, run_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    logic [7:0]             prev_byte;
    logic                   p, p1, p2, close;
    logic [OFFSET_BITS-1:0] run, pos, run_inc, pos_inc, close_run;
    logic [CW-1:0]          run_ext, min_ext, min_plus;
    logic                   ge_min, ge_min1, wide;

    // chunk start acts as if the state had just been cleared
    assign prev_byte = chunk_start ? 8'd0 : prev_byte_reg;
    assign p1        = chunk_start ? 1'b0 : p1_reg;
    assign p2        = chunk_start ? 1'b0 : p2_reg;
    assign run       = chunk_start ? '0 : run_reg;
    assign pos       = chunk_start ? '0 : pos_reg;

    assign p = (cfg.control_printable && (data_byte == pse_pkg::CHAR_TAB
                || data_byte == pse_pkg::CHAR_LF || data_byte == pse_pkg::CHAR_CR))
               || (data_byte >= cfg.printable_low && data_byte <= cfg.printable_high);

    assign run_inc  = (&run) ? run : run + 1'b1;
    assign pos_inc  = (&pos) ? pos : pos + 1'b1;
    assign run_ext  = CW'(run);
    assign min_ext  = CW'(cfg.min_length);
    assign min_plus = min_ext + 1'b1;
    assign ge_min   = (run_ext >= min_ext);
    assign ge_min1  = (run_ext >= min_plus);
    assign wide     = (p1 == p);

    always_comb
    begin
        run_next  = run;
        close     = 1'b0;
        close_run = run;
        priority if (p2 && p1)
        begin
            if (p)
                run_next = run_inc;
            else if (ge_min)
                close = 1'b1;
            else
                run_next = (data_byte == 8'd0) ? OFFSET_BITS'(1) : '0;
        end
        else if (p2 && !p1)
        begin
            if (p)
            begin
                if (prev_byte == 8'd0)
                    run_next = run_inc;
            end
            else if (ge_min)
                close = 1'b1;
            else
                run_next = '0;
        end
        else if (!p2 && p1)
        begin
            if (p)
            begin
                if (ge_min1)
                begin
                    // last char belongs to the next run
                    close     = 1'b1;
                    close_run = run - 1'b1;
                end
                else
                    run_next = OFFSET_BITS'(2);
            end
        end
        else
        begin
            if (p)
                run_next = run_inc;
        end
        if (close)
            run_next = '0;
        prev_byte_next = data_byte;
        p2_next        = p1;
        p1_next        = p;
        pos_next       = pos_inc;
    end

    assign rec_valid = in_valid && close && !(wide && !cfg.detect_wide);
    assign rec_run   = close_run;
    assign rec_pos   = pos;
    assign rec_bias  = p;
    assign rec_wide  = wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            run_reg       <= '0;
            pos_reg       <= '0;
        end
        else if (in_valid)
        begin
            prev_byte_reg <= prev_byte_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            run_reg       <= run_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

// File: src/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back: result builder
// Turns a close record into byte length and start offset, saturated to the
// result width, and hands it to the output queue.
// ----------------------------------------------------------------------------
module pse_back #(
    parameter int OFFSET_BITS = 28
) (
    input  logic                   rec_empty,
    input  logic [OFFSET_BITS-1:0] rec_run,
    input  logic [OFFSET_BITS-1:0] rec_pos,
    input  logic                   rec_bias,
    input  logic                   rec_wide,
    output logic                   rec_pop,
    input  logic                   res_full,
    output logic                   res_push,
    output pse_pkg::result_t       res
);

    localparam int EW = (OFFSET_BITS > pse_pkg::OUT_W) ? OFFSET_BITS : pse_pkg::OUT_W;

    logic [OFFSET_BITS-1:0] bytes;
    logic [OFFSET_BITS:0]   back, pos_ext, start;
    logic [EW-1:0]          start_ext, bytes_ext, limit_ext;

    // doubling overflows only when the top bit is set
    always_comb
    begin
        if (!rec_wide)
            bytes = rec_run;
        else if (rec_run[OFFSET_BITS-1])
            bytes = '1;
        else
            bytes = {rec_run[OFFSET_BITS-2:0], 1'b0};
    end

    assign back    = {1'b0, bytes} + (OFFSET_BITS+1)'(rec_bias);
    assign pos_ext = {1'b0, rec_pos};
    assign start   = (pos_ext >= back) ? pos_ext - back : '0;

    assign start_ext = EW'(start[OFFSET_BITS-1:0]);
    assign bytes_ext = EW'(bytes);
    assign limit_ext = EW'(pse_pkg::OUT_LIMIT);

    assign res.start_offset = (start_ext > limit_ext) ? pse_pkg::OUT_LIMIT
                                                      : start_ext[pse_pkg::OUT_W-1:0];
    assign res.length_bytes = (bytes_ext > limit_ext) ? pse_pkg::OUT_LIMIT
                                                      : bytes_ext[pse_pkg::OUT_W-1:0];
    assign res.is_wide      = rec_wide;

    assign rec_pop  = !rec_empty && !res_full;
    assign res_push = rec_pop;

endmodule

// File: src/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker: port-level checks
// Watches the top level's ports for queue and reset behaviour.
// ----------------------------------------------------------------------------
module pse_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      full,
    input  logic                      empty,
    input  logic                      pop,
    input  logic                      cfg_ready,
    input  logic [pse_pkg::OUT_W-1:0] start_offset,
    input  logic [pse_pkg::OUT_W-1:0] length_bytes,
    input  logic                      is_wide
);

    // a waiting result that is not popped stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(start_offset)
                              && $stable(length_bytes) && $stable(is_wide)))
        else $error("pending result changed before pop");

    // input side only backs up once results pile up at the output
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled while no result waits");

    // an edge seen in reset leaves both queues clear
    a_reset: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind printable_string_extractor_core pse_checker u_pse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .cfg_ready    (cfg_ready),
    .start_offset (start_offset),
    .length_bytes (length_bytes),
    .is_wide      (is_wide)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for printable_string_extractor_core
// Streams directed and random byte sequences (narrow and wide strings, noise,
// chunk restarts) under a series of register settings, predicts every string
// record with a cycle-free model and checks each popped record field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int POS_BITS = 28;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 152;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_WAIT = 14;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } scan_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [7:0] data_byte = '0;
    logic chunk_start = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [pse_pkg::OUT_W-1:0] start_offset;
    logic [pse_pkg::OUT_W-1:0] length_bytes;
    logic is_wide;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pse_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pse_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // byte feed and record sink
    scan_item_t byte_queue[$];
    scan_item_t cur_item;
    pse_pkg::result_t expected_strings[$];
    pse_pkg::result_t want;
    int queued_total = 0;
    int error_count = 0;
    logic byte_taken = 1'b0;
    logic rec_taken = 1'b0;
    logic nxt_push;
    logic nxt_pop;
    int src_wait = 0;
    int sink_wait = 0;
    logic src_burst = 1'b0;
    logic sink_burst = 1'b0;

    // shadow of the scanner
    pse_pkg::cfg_t shadow_cfg = pse_pkg::CFG_RESET;
    logic [7:0] last_byte = '0;
    logic last_prn = 1'b0;
    logic prior_prn = 1'b0;
    logic [POS_BITS-1:0] run_chars = '0;
    logic [POS_BITS-1:0] scan_pos = '0;

    printable_string_extractor_core #(
        .OFFSET_BITS(POS_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .chunk_start  (chunk_start),
        .empty        (empty),
        .pop          (pop),
        .start_offset (start_offset),
        .length_bytes (length_bytes),
        .is_wide      (is_wide),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic classify(input pse_pkg::cfg_t c, input logic [7:0] b);
        if (c.control_printable && (b == pse_pkg::CHAR_TAB || b == pse_pkg::CHAR_LF
                                    || b == pse_pkg::CHAR_CR))
            return 1'b1;
        return (b >= c.printable_low) && (b <= c.printable_high);
    endfunction

    function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    task automatic apply_reg(input logic [pse_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pse_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            pse_pkg::REG_MIN_LENGTH:        shadow_cfg.min_length = val;
            pse_pkg::REG_DETECT_WIDE:       shadow_cfg.detect_wide = val[0];
            pse_pkg::REG_PRINTABLE_LOW:     shadow_cfg.printable_low = val[7:0];
            pse_pkg::REG_PRINTABLE_HIGH:    shadow_cfg.printable_high = val[7:0];
            pse_pkg::REG_CONTROL_PRINTABLE: shadow_cfg.control_printable = val[0];
            default: ;
        endcase
    endtask

    // Advance the shadow scanner by one byte; queue a record if a run closes.
    task automatic scan_byte(input logic [7:0] b, input logic restart);
        logic p;
        logic p1;
        logic p2;
        logic closing;
        logic wide_run;
        logic [POS_BITS:0] n_bytes;
        logic [POS_BITS:0] back;
        pse_pkg::result_t rec;
        if (restart)
        begin
            last_byte = '0;
            last_prn = 1'b0;
            prior_prn = 1'b0;
            run_chars = '0;
            scan_pos = '0;
        end
        p = classify(shadow_cfg, b);
        p1 = last_prn;
        p2 = prior_prn;
        closing = 1'b0;
        case ({p2, p1})
            2'b11:
            begin
                if (p)
                    run_chars = bump(run_chars);
                else if (run_chars >= shadow_cfg.min_length)
                    closing = 1'b1;
                else
                    run_chars = (b == 8'h00) ? POS_BITS'(1) : '0;
            end
            2'b10:
            begin
                // zero byte between two printables: wide character continues
                if (p)
                begin
                    if (last_byte == 8'h00)
                        run_chars = bump(run_chars);
                end
                else if (run_chars >= shadow_cfg.min_length)
                    closing = 1'b1;
                else
                    run_chars = '0;
            end
            2'b01:
            begin
                if (p)
                begin
                    if (run_chars > shadow_cfg.min_length)
                    begin
                        run_chars = run_chars - 1'b1;
                        closing = 1'b1;
                    end
                    else
                        run_chars = POS_BITS'(2);
                end
            end
            default:
            begin
                if (p)
                    run_chars = bump(run_chars);
            end
        endcase

        if (closing)
        begin
            wide_run = (p1 == p);
            n_bytes = {1'b0, run_chars};
            if (wide_run)
            begin
                n_bytes = n_bytes << 1;
                if (n_bytes > POS_MAX)
                    n_bytes = POS_MAX;
            end
            back = n_bytes + p;
            rec.start_offset = ({1'b0, scan_pos} >= back)
                               ? scan_pos - back[POS_BITS-1:0] : '0;
            rec.length_bytes = n_bytes[POS_BITS-1:0];
            rec.is_wide = wide_run;
            if (!(wide_run && !shadow_cfg.detect_wide))
                expected_strings.push_back(rec);
            run_chars = '0;
        end

        last_byte = b;
        prior_prn = p1;
        last_prn = p;
        scan_pos = bump(scan_pos);
    endtask

    // byte source: hold each request until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            nxt_push = 1'b0;
        else
        begin
            nxt_push = push && !byte_taken;
            if (!nxt_push)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (byte_queue.size() > 0)
                begin
                    cur_item = byte_queue.pop_front();
                    data_byte <= cur_item.data;
                    chunk_start <= cur_item.restart;
                    nxt_push = 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        src_burst = !src_burst;
                    src_wait = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
                end
            end
        end
        push <= nxt_push;
    end

    // record sink
    always @(negedge clk)
    begin
        if (!rst_n)
            nxt_pop = 1'b0;
        else if (pop && rec_taken)
        begin
            if ($urandom_range(0, 63) == 0)
                sink_burst = !sink_burst;
            sink_wait = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
            nxt_pop = (sink_wait == 0);
        end
        else if (!pop)
        begin
            if (sink_wait > 0)
                sink_wait--;
            nxt_pop = (sink_wait == 0);
        end
        else
            nxt_pop = 1'b1;
        pop <= nxt_pop;
    end

    always @(posedge clk)
    begin
        byte_taken = rst_n && push && !full;
        rec_taken = rst_n && pop && !empty;
        if (rst_n && cfg_valid && cfg_ready)
            apply_reg(cfg_index, cfg_data);
        if (byte_taken)
            scan_byte(data_byte, chunk_start);
        if (rec_taken)
        begin
            if (expected_strings.size() == 0)
            begin
                $error("string record with none expected: start %0d length %0d wide %0b",
                       start_offset, length_bytes, is_wide);
                error_count++;
            end
            else
            begin
                want = expected_strings.pop_front();
                if (start_offset !== want.start_offset)
                begin
                    $error("start_offset: expected %0d, got %0d", want.start_offset, start_offset);
                    error_count++;
                end
                if (length_bytes !== want.length_bytes)
                begin
                    $error("length_bytes: expected %0d, got %0d", want.length_bytes, length_bytes);
                    error_count++;
                end
                if (is_wide !== want.is_wide)
                begin
                    $error("is_wide: expected %0b, got %0b", want.is_wide, is_wide);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic restart);
        scan_item_t it;
        it.data = b;
        it.restart = restart;
        byte_queue.push_back(it);
        queued_total++;
    endtask

    function automatic logic [7:0] pick_byte(input pse_pkg::cfg_t c, input logic want_prn);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        for (int t = 0; t < 64 && classify(c, b) != want_prn; t++)
        begin
            if (want_prn && c.printable_low <= c.printable_high && $urandom_range(0, 7) != 0)
                b = 8'($urandom_range(c.printable_high, c.printable_low));
            else if (want_prn && c.control_printable)
            begin
                case ($urandom_range(0, 2))
                    0: b = pse_pkg::CHAR_TAB;
                    1: b = pse_pkg::CHAR_LF;
                    default: b = pse_pkg::CHAR_CR;
                endcase
            end
            else
                b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task automatic write_reg(input logic [pse_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pse_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_config(input pse_pkg::cfg_t c);
        write_reg(pse_pkg::REG_MIN_LENGTH, c.min_length);
        write_reg(pse_pkg::REG_DETECT_WIDE, {15'd0, c.detect_wide});
        write_reg(pse_pkg::REG_PRINTABLE_LOW, {8'd0, c.printable_low});
        write_reg(pse_pkg::REG_PRINTABLE_HIGH, {8'd0, c.printable_high});
        write_reg(pse_pkg::REG_CONTROL_PRINTABLE, {15'd0, c.control_printable});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all bytes taken, all records popped, then let the pipeline settle
    task automatic wait_idle();
        while (byte_queue.size() != 0 || push)
            @(posedge clk);
        while (expected_strings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] directed [25];
        pse_pkg::cfg_t phase_cfg;
        int ml;
        int n_chars;
        int n_gap;
        int n_noise;
        int phase_start;
        logic wide_seg;
        logic first_restart;

        // narrow run, controls in a run, wide run, run dropped by a new chunk
        directed = '{8'h41, 8'h42, 8'h43, 8'h44, 8'hFF,
                     pse_pkg::CHAR_TAB, pse_pkg::CHAR_LF, pse_pkg::CHAR_CR,
                     8'h20, 8'h7E, 8'h7F,
                     8'h57, 8'h00, 8'h49, 8'h00, 8'h44, 8'h00, 8'h45, 8'h00, 8'h00, 8'h01,
                     8'h41, 8'h42, 8'h43, 8'h44};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_config(pse_pkg::CFG_RESET);
        for (int i = 0; i < 25; i++)
            queue_byte(directed[i], i == 0 || i == 24);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            phase_cfg = pse_pkg::CFG_RESET;
            if (ph == 0)
            begin
                // everything printable, nothing extra
                phase_cfg.min_length = 16'd0;
                phase_cfg.detect_wide = 1'b0;
                phase_cfg.printable_low = 8'd0;
                phase_cfg.printable_high = 8'd255;
                phase_cfg.control_printable = 1'b0;
            end
            else if (ph == 1)
            begin
                // empty range: only tab, line feed and carriage return count
                phase_cfg.min_length = 16'hFFFF;
                phase_cfg.printable_low = 8'd255;
                phase_cfg.printable_high = 8'd0;
            end
            else if (ph == 2)
            begin
                phase_cfg.min_length = 16'd1;
                phase_cfg.control_printable = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: phase_cfg.min_length = 16'($urandom_range(0, 8));
                    7: phase_cfg.min_length = 16'($urandom_range(9, 24));
                    8: phase_cfg.min_length = 16'($urandom_range(0, 65535));
                    default: phase_cfg.min_length = 16'hFFFF;
                endcase
                phase_cfg.detect_wide = 1'($urandom_range(0, 1));
                phase_cfg.control_printable = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 5) == 0)
                begin
                    phase_cfg.printable_low = 8'($urandom_range(0, 255));
                    phase_cfg.printable_high = 8'($urandom_range(0, 255));
                end
                else
                begin
                    phase_cfg.printable_low = 8'($urandom_range(0, 64));
                    phase_cfg.printable_high = 8'($urandom_range(96, 255));
                end
            end
            write_config(phase_cfg);

            phase_start = queued_total;
            while (queued_total - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    // string around the minimum, then a short break
                    wide_seg = 1'($urandom_range(0, 1));
                    first_restart = ($urandom_range(0, 31) == 0);
                    ml = phase_cfg.min_length;
                    if (ml > 30)
                        n_chars = $urandom_range(1, 30);
                    else
                        n_chars = $urandom_range(ml + 6, (ml > 2) ? ml - 2 : 0);
                    for (int k = 0; k < n_chars; k++)
                    begin
                        queue_byte(pick_byte(phase_cfg, 1'b1), first_restart && k == 0);
                        if (wide_seg)
                            queue_byte(8'h00, 1'b0);
                    end
                    n_gap = $urandom_range(1, 3);
                    for (int k = 0; k < n_gap; k++)
                        queue_byte(pick_byte(phase_cfg, 1'b0), 1'b0);
                end
                else
                begin
                    n_noise = $urandom_range(1, 6);
                    for (int k = 0; k < n_noise; k++)
                        queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                end
            end
            wait_idle();
        end

        if (error_count == 0 && expected_strings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
